>>> design/otd_pkg.sv
// Shared types, widths and the control store for the ordered record table.
// Used by otd_dp, ordered_table_delete_by_key and otd_check.
package otd_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int OCNT_W = 7;
  localparam int REQ_W  = 2;
  localparam int STS_W  = 2;
  localparam int STEP_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // control store addresses
  localparam logic [STEP_W-1:0] S_IDLE      = 3'd0;
  localparam logic [STEP_W-1:0] S_APPEND    = 3'd1;
  localparam logic [STEP_W-1:0] S_DEL_WALK  = 3'd2;
  localparam logic [STEP_W-1:0] S_DEL_DONE  = 3'd3;
  localparam logic [STEP_W-1:0] S_DMP_WALK  = 3'd4;
  localparam logic [STEP_W-1:0] S_DMP_EMPTY = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_COMPACT,
    OP_DEL_RESULT,
    OP_EMIT,
    OP_EMPTY
  } op_t;

  typedef enum logic [1:0] {
    C_DISPATCH,
    C_OUT_FREE,
    C_WALK_DONE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } cword_t;

  // sequencer -> datapath
  typedef struct packed {
    logic accept;
    op_t  op;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic slot_free;
    logic walk_done;
    logic empty;
  } sts_t;

  function automatic cword_t ucode(input logic [STEP_W-1:0] step);
    cword_t cw;
    case (step)
      S_IDLE:      cw = '{op: OP_NONE,       cond: C_DISPATCH,  target: S_IDLE};
      S_APPEND:    cw = '{op: OP_APPEND,     cond: C_OUT_FREE,  target: S_IDLE};
      S_DEL_WALK:  cw = '{op: OP_COMPACT,    cond: C_WALK_DONE, target: S_DEL_DONE};
      S_DEL_DONE:  cw = '{op: OP_DEL_RESULT, cond: C_OUT_FREE,  target: S_IDLE};
      S_DMP_WALK:  cw = '{op: OP_EMIT,       cond: C_WALK_DONE, target: S_IDLE};
      S_DMP_EMPTY: cw = '{op: OP_EMPTY,      cond: C_OUT_FREE,  target: S_IDLE};
      default:     cw = '{op: OP_NONE,       cond: C_DISPATCH,  target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> design/otd_dp.sv
// Datapath of the ordered record table: record memory, walk pointers,
// record count and the output word register. Depends on otd_pkg.
module otd_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  otd_pkg::ctl_t                ctl,
  input  logic [otd_pkg::KEY_W-1:0]    in_key,
  input  logic signed [otd_pkg::VAL_W-1:0] in_value,
  output otd_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [otd_pkg::KEY_W-1:0]    out_key,
  output logic signed [otd_pkg::VAL_W-1:0] out_value,
  output logic [otd_pkg::OCNT_W-1:0]   out_count,
  output logic [otd_pkg::STS_W-1:0]    out_status,
  output logic                         out_last
);

  logic [otd_pkg::KEY_W-1:0] key_mem [otd_pkg::DEPTH];
  logic [otd_pkg::VAL_W-1:0] val_mem [otd_pkg::DEPTH];

  logic [otd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [otd_pkg::CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [otd_pkg::CNT_W-1:0] kept_r, kept_nxt;
  logic [otd_pkg::CNT_W-1:0] removed_r, removed_nxt;
  logic                      pend_r, pend_nxt;
  logic [otd_pkg::KEY_W-1:0] key_r;
  logic [otd_pkg::VAL_W-1:0] val_r;
  logic [otd_pkg::KEY_W-1:0] rd_key_r;
  logic [otd_pkg::VAL_W-1:0] rd_val_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [otd_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [otd_pkg::VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [otd_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [otd_pkg::STS_W-1:0]  out_status_r, out_status_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_load;

  logic                        slot_free, walking, adv, issue, match, full;
  logic                        wr_en;
  logic [otd_pkg::ADDR_W-1:0]  wr_addr;
  logic [otd_pkg::KEY_W-1:0]   wr_key;
  logic [otd_pkg::VAL_W-1:0]   wr_val;

  assign slot_free = !out_valid_r || !out_stall;
  assign walking   = (ctl.op == otd_pkg::OP_COMPACT) || (ctl.op == otd_pkg::OP_EMIT);
  // a dump walk holds while its fetched record cannot be handed on
  assign adv       = !((ctl.op == otd_pkg::OP_EMIT) && pend_r && !slot_free);
  assign issue     = walking && adv && (rd_idx_r < cnt_r);
  assign match     = (rd_key_r == key_r);
  assign full      = (cnt_r == otd_pkg::CNT_W'(otd_pkg::DEPTH));

  assign sts.slot_free = slot_free;
  assign sts.walk_done = walking && adv && !issue;
  assign sts.empty     = (cnt_r == '0);

  always_comb begin
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    kept_nxt       = kept_r;
    removed_nxt    = removed_r;
    pend_nxt       = pend_r;
    wr_en          = 1'b0;
    wr_addr        = kept_r[otd_pkg::ADDR_W-1:0];
    wr_key         = rd_key_r;
    wr_val         = rd_val_r;
    out_load       = 1'b0;
    out_key_nxt    = '0;
    out_value_nxt  = '0;
    out_count_nxt  = '0;
    out_status_nxt = otd_pkg::ST_OK;
    out_last_nxt   = 1'b1;

    if (ctl.accept) begin
      rd_idx_nxt  = '0;
      kept_nxt    = '0;
      removed_nxt = '0;
      pend_nxt    = 1'b0;
    end

    case (ctl.op)
      otd_pkg::OP_APPEND: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (full) begin
            out_count_nxt  = cnt_r;
            out_status_nxt = otd_pkg::ST_FULL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = cnt_r[otd_pkg::ADDR_W-1:0];
            wr_key        = key_r;
            wr_val        = val_r;
            cnt_nxt       = cnt_r + 1'b1;
            out_count_nxt = cnt_r + 1'b1;
          end
        end
      end
      otd_pkg::OP_COMPACT: begin
        // survivors slide down to the kept pointer, which trails the read pointer
        if (pend_r) begin
          if (match) begin
            removed_nxt = removed_r + 1'b1;
          end else begin
            wr_en    = 1'b1;
            kept_nxt = kept_r + 1'b1;
          end
        end
      end
      otd_pkg::OP_DEL_RESULT: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_count_nxt = removed_r;
          cnt_nxt       = kept_r;
        end
      end
      otd_pkg::OP_EMIT: begin
        if (pend_r && slot_free) begin
          out_load      = 1'b1;
          out_key_nxt   = rd_key_r;
          out_value_nxt = rd_val_r;
          out_last_nxt  = (rd_idx_r == cnt_r);
        end
      end
      otd_pkg::OP_EMPTY: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_status_nxt = otd_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase

    if (walking && adv) begin
      pend_nxt = issue;
      if (issue) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      kept_r      <= '0;
      removed_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      kept_r      <= kept_nxt;
      removed_r   <= removed_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      key_r <= in_key;
      val_r <= in_value;
    end
    if (out_load) begin
      out_key_r    <= out_key_nxt;
      out_value_r  <= out_value_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (issue) begin
      rd_key_r <= key_mem[rd_idx_r[otd_pkg::ADDR_W-1:0]];
      rd_val_r <= val_mem[rd_idx_r[otd_pkg::ADDR_W-1:0]];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_key    = out_key_r;
  assign out_value  = out_value_r;
  assign out_count  = otd_pkg::OCNT_W'(out_count_r);
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

>>> design/ordered_table_delete_by_key.sv
// Top level of the ordered record table: control store sequencer driving otd_dp.
// Depends on otd_pkg and otd_dp.
//
//   channel | dir | handshake           | word
//   in_     | in  | in_valid / in_stall | in_req_type, in_key, in_value
//   out_    | out | out_valid/out_stall | out_key, out_value, out_count, out_status, out_last
//
// For N stored records a delete walks all N and then reports, and a dump walks all N
// (or reports empty); the single read port of the record memory walks one record a
// cycle unless a stalled output holds a dump walk. A new request is taken only in the idle step.
// A stalled output word holds a dump walk and any step that loads a word; a delete
// walk runs on, and the next request is taken while a final word waits.
// Reset is synchronous, active low, and empties the table; no clearing pass.
module ordered_table_delete_by_key (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [otd_pkg::REQ_W-1:0]        in_req_type,
  input  logic [otd_pkg::KEY_W-1:0]        in_key,
  input  logic signed [otd_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [otd_pkg::KEY_W-1:0]        out_key,
  output logic signed [otd_pkg::VAL_W-1:0] out_value,
  output logic [otd_pkg::OCNT_W-1:0]       out_count,
  output logic [otd_pkg::STS_W-1:0]        out_status,
  output logic                             out_last
);

  logic [otd_pkg::STEP_W-1:0] step_r, step_nxt;
  otd_pkg::cword_t            cw;
  otd_pkg::ctl_t              ctl;
  otd_pkg::sts_t              sts;
  logic                       accept;

  assign cw       = otd_pkg::ucode(step_r);
  assign in_stall = (step_r != otd_pkg::S_IDLE);
  assign accept   = in_valid && (step_r == otd_pkg::S_IDLE);

  assign ctl.accept = accept;
  assign ctl.op     = cw.op;

  always_comb begin
    step_nxt = step_r;
    case (cw.cond)
      otd_pkg::C_DISPATCH: begin
        if (accept) begin
          case (in_req_type)
            otd_pkg::REQ_APPEND: step_nxt = otd_pkg::S_APPEND;
            otd_pkg::REQ_DELETE: step_nxt = otd_pkg::S_DEL_WALK;
            otd_pkg::REQ_DUMP:
              step_nxt = sts.empty ? otd_pkg::S_DMP_EMPTY : otd_pkg::S_DMP_WALK;
            default:             step_nxt = otd_pkg::S_IDLE;
          endcase
        end
      end
      otd_pkg::C_OUT_FREE: begin
        if (sts.slot_free) begin
          step_nxt = cw.target;
        end
      end
      otd_pkg::C_WALK_DONE: begin
        if (sts.walk_done) begin
          step_nxt = cw.target;
        end
      end
      default: step_nxt = otd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= otd_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  otd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_key     (in_key),
    .in_value   (in_value),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule

>>> design/otd_check.sv
// Port-level checks for ordered_table_delete_by_key, bound to the top level.
// Depends on otd_pkg.
module otd_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [otd_pkg::REQ_W-1:0]        in_req_type,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [otd_pkg::KEY_W-1:0]        out_key,
  input logic signed [otd_pkg::VAL_W-1:0] out_value,
  input logic [otd_pkg::OCNT_W-1:0]       out_count,
  input logic [otd_pkg::STS_W-1:0]        out_status,
  input logic                             out_last
);

  // a held output word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_key) && $stable(out_value)
      && $stable(out_count) && $stable(out_status) && $stable(out_last))
    else $error("output word changed while stalled");

  // a real request keeps the input side busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == otd_pkg::REQ_APPEND
      || in_req_type == otd_pkg::REQ_DELETE || in_req_type == otd_pkg::REQ_DUMP)
    |=> in_stall)
    else $error("request taken while previous one in progress");

  // full and empty reports are single words carrying no record
  a_short_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == otd_pkg::ST_FULL || out_status == otd_pkg::ST_EMPTY)
    |-> out_last && out_key == '0 && out_value == '0)
    else $error("status word malformed");

  // no output word straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ordered_table_delete_by_key otd_check u_otd_check (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for ordered_table_delete_by_key: append, delete-by-key and dump traffic
// with random input gaps and output stalls, checked against an in-bench record table.
// Depends on otd_pkg and the block's RTL.
module tb;

  localparam logic [otd_pkg::REQ_W-1:0]        REQ_UNUSED = 2'd3;
  localparam logic signed [otd_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(otd_pkg::VAL_W-1){1'b0}}};
  localparam logic signed [otd_pkg::VAL_W-1:0] VAL_MAX = ~VAL_MIN;
  localparam logic [otd_pkg::KEY_W-1:0]        KEY_MAX = '1;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct {
    logic [otd_pkg::KEY_W-1:0]        key;
    logic signed [otd_pkg::VAL_W-1:0] value;
    logic [otd_pkg::OCNT_W-1:0]       count;
    logic [otd_pkg::STS_W-1:0]        status;
    logic                             last;
  } result_word_t;

  // Mirror of the table contents plus the words each accepted request must produce.
  class record_table;
    logic [otd_pkg::KEY_W-1:0]        keys [otd_pkg::DEPTH];
    logic signed [otd_pkg::VAL_W-1:0] vals [otd_pkg::DEPTH];
    int unsigned             held = 0;
    result_word_t            due [$];
    int errors = 0;
    int words_checked = 0;
    int n_append = 0, n_full = 0, n_delete = 0, n_removed = 0, n_dump = 0, n_unused = 0;

    function void note_request(logic [otd_pkg::REQ_W-1:0] req,
                               logic [otd_pkg::KEY_W-1:0] key,
                               logic signed [otd_pkg::VAL_W-1:0] value);
      result_word_t w;
      int unsigned kept;
      int unsigned removed;
      w = '{key: '0, value: '0, count: '0, status: otd_pkg::ST_OK, last: 1'b1};
      case (req)
        otd_pkg::REQ_APPEND: begin
          n_append++;
          if (held >= otd_pkg::DEPTH) begin
            w.status = otd_pkg::ST_FULL;
            n_full++;
          end else begin
            keys[held] = key;
            vals[held] = value;
            held++;
          end
          w.count = otd_pkg::OCNT_W'(held);
          due.push_back(w);
        end
        otd_pkg::REQ_DELETE: begin
          n_delete++;
          kept = 0;
          removed = 0;
          // survivors slide down in order
          for (int unsigned i = 0; i < held; i++) begin
            if (keys[i] == key) begin
              removed++;
            end else begin
              keys[kept] = keys[i];
              vals[kept] = vals[i];
              kept++;
            end
          end
          held = kept;
          n_removed += removed;
          w.count = otd_pkg::OCNT_W'(removed);
          due.push_back(w);
        end
        otd_pkg::REQ_DUMP: begin
          n_dump++;
          if (held == 0) begin
            w.status = otd_pkg::ST_EMPTY;
            due.push_back(w);
          end else begin
            for (int unsigned i = 0; i < held; i++) begin
              w.key   = keys[i];
              w.value = vals[i];
              w.last  = (i + 1 == held);
              due.push_back(w);
            end
          end
        end
        default: n_unused++;
      endcase
    endfunction

    function void check_word(logic [otd_pkg::KEY_W-1:0] k,
                             logic signed [otd_pkg::VAL_W-1:0] v,
                             logic [otd_pkg::OCNT_W-1:0] c,
                             logic [otd_pkg::STS_W-1:0] s, logic l);
      result_word_t exp_w;
      words_checked++;
      if (due.size() == 0) begin
        $error("unexpected result word: key %0d value %0d count %0d status %0d last %0d",
               k, v, c, s, l);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      if (k !== exp_w.key) begin
        $error("out_key: expected %0d, got %0d", exp_w.key, k);
        errors++;
      end
      if (v !== exp_w.value) begin
        $error("out_value: expected %0d, got %0d", exp_w.value, v);
        errors++;
      end
      if (c !== exp_w.count) begin
        $error("out_count: expected %0d, got %0d", exp_w.count, c);
        errors++;
      end
      if (s !== exp_w.status) begin
        $error("out_status: expected %0d, got %0d", exp_w.status, s);
        errors++;
      end
      if (l !== exp_w.last) begin
        $error("out_last: expected %0d, got %0d", exp_w.last, l);
        errors++;
      end
    endfunction

    // mostly a key that is present, so deletes actually remove records
    function logic [otd_pkg::KEY_W-1:0] stored_key();
      if (held == 0) return otd_pkg::KEY_W'($urandom_range(6, 1));
      return keys[$urandom_range(held - 1)];
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [otd_pkg::REQ_W-1:0]        in_req_type = otd_pkg::REQ_APPEND;
  logic [otd_pkg::KEY_W-1:0]        in_key = '0;
  logic signed [otd_pkg::VAL_W-1:0] in_value = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [otd_pkg::KEY_W-1:0]        out_key;
  logic signed [otd_pkg::VAL_W-1:0] out_value;
  logic [otd_pkg::OCNT_W-1:0]       out_count;
  logic [otd_pkg::STS_W-1:0]        out_status;
  logic                             out_last;

  record_table sb = new();

  int  words_in = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  int  burst_left = 0;
  bit  held_once = 1'b0;
  bit  tail_quiet = 1'b0;

  ordered_table_delete_by_key DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req_type(in_req_type),
    .in_key     (in_key),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_count  (out_count),
    .out_status (out_status),
    .out_last   (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // windows with no idling on either side
  function automatic bit calm();
    return ((words_in / 16) % 4) == 3;
  endfunction

  function automatic logic [otd_pkg::KEY_W-1:0] any_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return KEY_MAX;
      2, 3:    return otd_pkg::KEY_W'($urandom());
      default: return otd_pkg::KEY_W'($urandom_range(6, 1));
    endcase
  endfunction

  function automatic logic signed [otd_pkg::VAL_W-1:0] any_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      default: return otd_pkg::VAL_W'($urandom());
    endcase
  endfunction

  task automatic offer(input logic [otd_pkg::REQ_W-1:0] req,
                       input logic [otd_pkg::KEY_W-1:0] key,
                       input logic signed [otd_pkg::VAL_W-1:0] value);
    int gap;
    gap = 0;
    if (!tail_quiet && !calm() && $urandom_range(99) < 30) gap = $urandom_range(5, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_key      <= key;
    in_value    <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req, key, value);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
  endtask

  // receiver: short stall bursts, one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held_once && words_in >= 40) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (tail_quiet || calm()) begin
      burst_left <= 0;
      out_stall  <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(99) < 15) begin
      burst_left <= $urandom_range(4, 0);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_key, out_value, out_count, out_status, out_last);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && in_valid && !in_stall) words_in <= words_in + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", quiet_cycles);
      $display("[ordered_table_delete_by_key] ERROR");
      $finish;
    end
  end

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, adjacent matches, head and tail deletes
    offer(otd_pkg::REQ_DUMP,   '0, '0);
    offer(otd_pkg::REQ_DELETE, 31'd5, '0);
    offer(otd_pkg::REQ_APPEND, '0, VAL_MIN);
    offer(otd_pkg::REQ_APPEND, KEY_MAX, VAL_MAX);
    offer(otd_pkg::REQ_APPEND, 31'd5, '0);
    offer(otd_pkg::REQ_APPEND, 31'd5, -1);
    offer(otd_pkg::REQ_APPEND, 31'd5, 1);
    offer(otd_pkg::REQ_APPEND, 31'd9, 2);
    offer(otd_pkg::REQ_APPEND, 31'd5, 3);
    offer(otd_pkg::REQ_DUMP,   '0, '0);
    offer(REQ_UNUSED, KEY_MAX, VAL_MIN);
    offer(otd_pkg::REQ_DELETE, 31'd5, VAL_MAX);
    offer(otd_pkg::REQ_DELETE, 31'd12345, '0);
    offer(otd_pkg::REQ_DUMP,   KEY_MAX, VAL_MAX);
    offer(otd_pkg::REQ_DELETE, '0, '0);
    offer(otd_pkg::REQ_DELETE, KEY_MAX, '0);
    offer(otd_pkg::REQ_DUMP,   '0, '0);
    offer(otd_pkg::REQ_DELETE, 31'd9, '0);
    offer(otd_pkg::REQ_DUMP,   '0, '0);
    offer(REQ_UNUSED, '0, '0);
    offer(otd_pkg::REQ_APPEND, KEY_MAX, '0);
    offer(otd_pkg::REQ_DUMP,   '0, '0);
    drain();

    // fill up well past full, with dumps along the way
    for (int i = 0; i < 80; i++) begin
      pick = $urandom_range(99);
      if (pick < 90) offer(otd_pkg::REQ_APPEND, any_key(), any_value());
      else if (pick < 97) offer(otd_pkg::REQ_DUMP, any_key(), any_value());
      else offer(REQ_UNUSED, any_key(), any_value());
    end

    // mixed traffic, deletes mostly of stored keys, ending without idling
    for (int i = 0; i < 60; i++) begin
      if (i == 30) drain();
      if (i == 40) tail_quiet <= 1'b1;
      pick = $urandom_range(99);
      if (pick < 30)
        offer(otd_pkg::REQ_DELETE,
              ($urandom_range(9) < 7) ? sb.stored_key() : any_key(), any_value());
      else if (pick < 75) offer(otd_pkg::REQ_APPEND, any_key(), any_value());
      else if (pick < 95) offer(otd_pkg::REQ_DUMP, any_key(), any_value());
      else offer(REQ_UNUSED, any_key(), any_value());
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("requests: %0d appends (%0d refused as full), %0d deletes removing %0d records,",
             sb.n_append, sb.n_full, sb.n_delete, sb.n_removed);
    $display("  %0d dumps, %0d unused codes; %0d result words checked, %0d mismatches",
             sb.n_dump, sb.n_unused, sb.words_checked, sb.errors);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("[ordered_table_delete_by_key] OK");
    end else begin
      $display("[ordered_table_delete_by_key] ERROR");
    end
    $finish;
  end

endmodule

>>> ordered_table_delete_by_key.f
design/otd_pkg.sv
design/otd_dp.sv
design/ordered_table_delete_by_key.sv
design/otd_check.sv
dv/tb.sv
